// File: rtl/bopt_pkg.sv
// Shared types, constants and text tables for the boot option token parser.
// No dependencies; imported by bopt_front, bopt_back and the top level.
`default_nettype none

package bopt_pkg;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_RUN_DOE   = 1'b0;
  localparam logic CFG_LOG_LEVEL = 1'b1;

  // Reset values of the configuration registers
  localparam logic       RST_RUN_DOE   = 1'b0;
  localparam logic [1:0] RST_LOG_LEVEL = 2'd1;

  // Log level codes
  localparam logic [1:0] LVL_INFO = 2'd1;

  // Token position: saturating character count
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
  localparam logic [POS_W-1:0] DOE_LEN  = 5'd5;
  localparam logic [POS_W-1:0] LEVEL_AT = 5'd12;
  localparam logic [POS_W-1:0] STACK_AT = 5'd8;
  localparam logic [POS_W-1:0] HEAP_AT  = 5'd7;

  // Prefix candidate bits
  localparam int unsigned PFX_DOE   = 0;
  localparam int unsigned PFX_LEVEL = 1;
  localparam int unsigned PFX_STACK = 2;
  localparam int unsigned PFX_HEAP  = 3;

  // Characters of note
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Classified command that travels from front to back
  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_SEP,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
  } cmd_t;

  // Line defaults held in the configuration registers
  typedef struct packed {
    logic       run_doe;
    logic [1:0] lvl;
  } cfg_t;

  // Size value parse phase
  typedef enum logic [1:0] {
    SZ_WAIT,
    SZ_DIGITS,
    SZ_DONE
  } size_phase_e;

  // Length of prefix k
  function automatic logic [POS_W-1:0] pfx_len(input logic [1:0] k);
    logic [POS_W-1:0] len;
    unique case (k)
      2'd0:    len = 5'd5;
      2'd1:    len = 5'd12;
      2'd2:    len = 5'd8;
      default: len = 5'd7;
    endcase
    return len;
  endfunction

  // Byte i of prefix k (text left aligned in 12 bytes)
  function automatic logic [7:0] pfx_byte(input logic [1:0] k, input logic [3:0] i);
    logic [95:0] txt;
    logic [95:0] sh;
    unique case (k)
      2'd0:    txt = {"--doe", 56'd0};
      2'd1:    txt = "--log-level=";
      2'd2:    txt = {"--stack=", 32'd0};
      default: txt = {"--heap=", 40'd0};
    endcase
    sh = txt << {i, 3'b000};
    return sh[95:88];
  endfunction

  // Length of level name k: debug DEBUG info INFO warn WARN error ERROR
  function automatic logic [POS_W-1:0] lvl_len(input logic [2:0] k);
    logic [POS_W-1:0] len;
    unique case (k)
      3'd2, 3'd3, 3'd4, 3'd5: len = 5'd4;
      default:                len = 5'd5;
    endcase
    return len;
  endfunction

  // Byte i of level name k (text left aligned in 5 bytes)
  function automatic logic [7:0] lvl_byte(input logic [2:0] k, input logic [2:0] i);
    logic [39:0] txt;
    logic [39:0] sh;
    unique case (k)
      3'd0:    txt = "debug";
      3'd1:    txt = "DEBUG";
      3'd2:    txt = {"info", 8'd0};
      3'd3:    txt = {"INFO", 8'd0};
      3'd4:    txt = {"warn", 8'd0};
      3'd5:    txt = {"WARN", 8'd0};
      3'd6:    txt = "error";
      default: txt = "ERROR";
    endcase
    sh = txt << {i, 3'b000};
    return sh[39:32];
  endfunction

endpackage

`default_nettype wire

// File: rtl/boot_option_token_parser.sv
// Boot option token parser, top level: configuration registers, front end,
// back end and checks. Depends on bopt_pkg, bopt_front and bopt_back.
//
// Feeds a command line one byte per push (op 0) and closes it with an end
// item (op 1), which yields one result holding the stack and heap sizes, the
// doe flag and the log level; character items yield no result. One item is
// taken every clock cycle while full is low. An end item passes through the
// front queue into the result register, which drives the output ports until
// a pop. The front queue holds two items; the only stall comes from the
// single result register: an end item waits at the queue head while the
// previous result is still unread, and full rises once the queue fills behind
// it. The user writes the defaults through the configuration port only while
// the block is idle (not enforced by the block); they apply to the next result.
`default_nettype none

module boot_option_token_parser
  import bopt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input queue side
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] ch_i,
  // Result queue side
  output logic            empty,
  input  wire logic       pop,
  output logic [63:0]     stack_bytes_o,
  output logic [63:0]     heap_bytes_o,
  output logic            run_doe_o,
  output logic [1:0]      lvl_code_o,
  // Configuration writes
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RUN_DOE:   cfg_d.run_doe = cfg_data_i[0];
        CFG_LOG_LEVEL: cfg_d.lvl     = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_doe <= RST_RUN_DOE;
      cfg_q.lvl     <= RST_LOG_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bopt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .ch_i        (ch_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bopt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .empty         (empty),
    .pop           (pop),
    .stack_bytes_o (stack_bytes_o),
    .heap_bytes_o  (heap_bytes_o),
    .run_doe_o     (run_doe_o),
    .lvl_code_o    (lvl_code_o)
  );

  // An end command taken by the back end shows a result next cycle
  a_end_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.kind == CMD_END) |=> !empty)
    else $error("end command taken but no result shown");

  // A result leaves only through a pop transfer
  a_result_leaves_by_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result dropped without a pop transfer");

  // A full queue always presents a command to the back end
  a_full_has_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("queue full but no command at the head");

endmodule

`default_nettype wire

// File: rtl/bopt_front.sv
// Front end: takes input items, classifies them and holds them in a
// two-entry queue for the back end. Depends on bopt_pkg.
`default_nettype none

module bopt_front
  import bopt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] ch_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       do_push;
  logic       do_pop;

  // Classify the incoming item
  always_comb begin
    cls.ch = ch_i;
    if (op_i == OP_END) begin
      cls.kind = CMD_END;
    end else if (ch_i == CH_SPACE || ch_i == CH_TAB || ch_i == CH_CR || ch_i == CH_LF) begin
      cls.kind = CMD_SEP;
    end else begin
      cls.kind = CMD_CHAR;
    end
  end

  // Queue control
  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bopt_back.sv
// Back end: token matcher, size accumulator, line values and the result
// register. Takes one classified command per cycle bar a stalled end. Depends on bopt_pkg.
`default_nettype none

module bopt_back
  import bopt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cmd_valid_i,
  output logic        cmd_ready_o,
  input  wire cmd_t   cmd_i,
  input  wire cfg_t   cfg_i,
  output logic        empty,
  input  wire logic   pop,
  output logic [63:0] stack_bytes_o,
  output logic [63:0] heap_bytes_o,
  output logic        run_doe_o,
  output logic [1:0]  lvl_code_o
);

  // Token state
  logic [POS_W-1:0] pos_q, pos_d;
  logic             in_tok_q, in_tok_d;
  logic [3:0]       pcand_q, pcand_d;
  logic [7:0]       lcand_q, lcand_d;
  size_phase_e      phase_q, phase_d;
  logic [63:0]      acc_q, acc_d;
  // Line state
  logic [63:0]      stack_q, stack_d;
  logic [63:0]      heap_q, heap_d;
  logic             doe_q, doe_d;
  logic [1:0]       lvl_q, lvl_d;
  logic             given_q, given_d;
  // Result register
  logic             out_valid_q;
  logic [63:0]      out_stack_q, out_heap_q;
  logic             out_doe_q;
  logic [1:0]       out_lvl_q;

  logic             take;
  logic             take_end;
  // Character path
  logic [3:0]       pc_new;
  logic [7:0]       lc_new;
  logic [POS_W-1:0] li;
  logic             size_en;
  logic             is_digit;
  logic [3:0]       digit;
  size_phase_e      ph_new;
  logic [63:0]      acc_new;
  // Token finish path
  logic [63:0]      stack_f, heap_f;
  logic             doe_f, given_f;
  logic [1:0]       lvl_f;
  logic [1:0]       code;

  assign take        = cmd_valid_i && cmd_ready_o;
  assign take_end    = take && (cmd_i.kind == CMD_END);
  assign cmd_ready_o = (cmd_i.kind != CMD_END) || !out_valid_q || pop;

  // Prefix and level name matching for one character
  always_comb begin
    pc_new = pcand_q;
    for (int k = 0; k < 4; k++) begin
      if (pos_q < pfx_len(2'(k)) && cmd_i.ch != pfx_byte(2'(k), pos_q[3:0])) begin
        pc_new[k] = 1'b0;
      end
    end
    li     = pos_q - LEVEL_AT;
    lc_new = lcand_q;
    if (pc_new[PFX_LEVEL] && pos_q >= LEVEL_AT) begin
      for (int k = 0; k < 8; k++) begin
        if (li < lvl_len(3'(k)) && cmd_i.ch != lvl_byte(3'(k), li[2:0])) begin
          lc_new[k] = 1'b0;
        end
      end
    end
  end

  // Size value: digits times ten, then an optional K/M/G scale
  always_comb begin
    is_digit = (cmd_i.ch >= CH_ZERO) && (cmd_i.ch <= CH_NINE);
    digit    = 4'(cmd_i.ch - CH_ZERO);
    size_en  = (pc_new[PFX_STACK] && pos_q >= STACK_AT) ||
               (pc_new[PFX_HEAP] && pos_q >= HEAP_AT);
    ph_new   = phase_q;
    acc_new  = acc_q;
    if (size_en) begin
      unique case (phase_q)
        SZ_WAIT: begin
          acc_new = is_digit ? {60'd0, digit} : 64'd0;
          ph_new  = is_digit ? SZ_DIGITS : SZ_DONE;
        end
        SZ_DIGITS: begin
          if (is_digit) begin
            acc_new = (acc_q << 3) + (acc_q << 1) + {60'd0, digit};
          end else begin
            priority case (cmd_i.ch)
              "K", "k": acc_new = acc_q << 10;
              "M", "m": acc_new = acc_q << 20;
              "G", "g": acc_new = acc_q << 30;
              default:  acc_new = acc_q;
            endcase
            ph_new = SZ_DONE;
          end
        end
        default: begin
          acc_new = acc_q;
        end
      endcase
    end
  end

  // Level code: first surviving name whose length was reached
  always_comb begin
    code = LVL_INFO;
    for (int k = 7; k >= 0; k--) begin
      if (lcand_q[k] && pos_q >= LEVEL_AT + lvl_len(3'(k))) begin
        code = 2'(k >> 1);
      end
    end
  end

  // Line values once the open token is closed
  always_comb begin
    stack_f = stack_q;
    heap_f  = heap_q;
    doe_f   = doe_q;
    lvl_f   = lvl_q;
    given_f = given_q;
    if (in_tok_q) begin
      priority if (pcand_q[PFX_DOE] && pos_q == DOE_LEN) begin
        doe_f = 1'b1;
      end else if (pcand_q[PFX_LEVEL] && pos_q > LEVEL_AT) begin
        lvl_f   = code;
        given_f = 1'b1;
      end else if (pcand_q[PFX_STACK] && pos_q > STACK_AT) begin
        stack_f = acc_q;
      end else if (pcand_q[PFX_HEAP] && pos_q > HEAP_AT) begin
        heap_f = acc_q;
      end else begin
        doe_f = doe_q;
      end
    end
  end

  // Next state per command kind
  always_comb begin
    pos_d    = pos_q;
    in_tok_d = in_tok_q;
    pcand_d  = pcand_q;
    lcand_d  = lcand_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    stack_d  = stack_q;
    heap_d   = heap_q;
    doe_d    = doe_q;
    lvl_d    = lvl_q;
    given_d  = given_q;
    if (take) begin
      unique case (cmd_i.kind)
        CMD_CHAR: begin
          pos_d    = (pos_q < POS_MAX) ? pos_q + 5'd1 : pos_q;
          in_tok_d = 1'b1;
          pcand_d  = pc_new;
          lcand_d  = lc_new;
          phase_d  = ph_new;
          acc_d    = acc_new;
        end
        CMD_SEP: begin
          pos_d    = '0;
          in_tok_d = 1'b0;
          pcand_d  = '1;
          lcand_d  = '1;
          phase_d  = SZ_WAIT;
          acc_d    = '0;
          stack_d  = stack_f;
          heap_d   = heap_f;
          doe_d    = doe_f;
          lvl_d    = lvl_f;
          given_d  = given_f;
        end
        CMD_END: begin
          pos_d    = '0;
          in_tok_d = 1'b0;
          pcand_d  = '1;
          lcand_d  = '1;
          phase_d  = SZ_WAIT;
          acc_d    = '0;
          stack_d  = '0;
          heap_d   = '0;
          doe_d    = 1'b0;
          lvl_d    = '0;
          given_d  = 1'b0;
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      in_tok_q <= 1'b0;
      pcand_q  <= '1;
      lcand_q  <= '1;
      phase_q  <= SZ_WAIT;
      acc_q    <= '0;
      stack_q  <= '0;
      heap_q   <= '0;
      doe_q    <= 1'b0;
      lvl_q    <= '0;
      given_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      in_tok_q <= in_tok_d;
      pcand_q  <= pcand_d;
      lcand_q  <= lcand_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      stack_q  <= stack_d;
      heap_q   <= heap_d;
      doe_q    <= doe_d;
      lvl_q    <= lvl_d;
      given_q  <= given_d;
    end
  end

  // Result register: loaded on an end command, freed by pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_end) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_end) begin
      out_stack_q <= stack_f;
      out_heap_q  <= heap_f;
      out_doe_q   <= doe_f | cfg_i.run_doe;
      out_lvl_q   <= given_f ? lvl_f : cfg_i.lvl;
    end
  end

  assign empty         = !out_valid_q;
  assign stack_bytes_o = out_stack_q;
  assign heap_bytes_o  = out_heap_q;
  assign run_doe_o     = out_doe_q;
  assign lvl_code_o    = out_lvl_q;

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for boot_option_token_parser: command lines go in one
// byte per transfer and the four option values parsed from each line are checked.
// Depends on bopt_pkg and the boot_option_token_parser RTL.
`default_nettype none

module tb;
  import bopt_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 8;     // quiet cycles before a default is rewritten
  localparam int LONG_HOLD   = 120;   // receiver hold-off that backs the block up
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic       op;
    logic [7:0] ch;
  } line_item_t;

  typedef struct {
    logic [63:0] stack;
    logic [63:0] heap;
    logic        doe;
    logic [1:0]  level;
  } boot_opts_t;

  // Block ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic        op_i        = OP_CHAR;
  logic [7:0]  ch_i        = 8'h00;
  logic        empty;
  logic        pop         = 1'b0;
  logic [63:0] stack_bytes_o;
  logic [63:0] heap_bytes_o;
  logic        run_doe_o;
  logic [1:0]  lvl_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_RUN_DOE;
  logic [1:0]  cfg_data_i  = 2'd0;

  boot_option_token_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .ch_i          (ch_i),
    .empty         (empty),
    .pop           (pop),
    .stack_bytes_o (stack_bytes_o),
    .heap_bytes_o  (heap_bytes_o),
    .run_doe_o     (run_doe_o),
    .lvl_code_o    (lvl_code_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Text the parser looks for
  string pfx_text [4] = '{"--doe", "--log-level=", "--stack=", "--heap="};
  string lvl_text [8] = '{"debug", "DEBUG", "info", "INFO", "warn", "WARN", "error", "ERROR"};
  string size_suffix = "kKmMgG";
  logic [7:0] sep_list [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  line_item_t pending_items [$];
  boot_opts_t expected_opts [$];

  // Control from the sequencing block
  bit hold_req;
  bit quiet;

  // Scoreboard counters
  int items_queued;
  int items_sent;
  int lines_checked;
  int stall_cycles;
  int mismatches;
  int idle_cycles;

  // Option parser state
  logic [4:0]  tok_len;
  logic        in_tok;
  logic [3:0]  pfx_live;
  logic [7:0]  name_live;
  size_phase_e num_phase;
  logic [63:0] num_acc;
  logic [63:0] stack_val;
  logic [63:0] heap_val;
  logic        doe_seen;
  logic [1:0]  level_val;
  logic        level_set;
  logic        dflt_doe   = RST_RUN_DOE;
  logic [1:0]  dflt_level = RST_LOG_LEVEL;

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic void clear_token();
    tok_len   = '0;
    in_tok    = 1'b0;
    pfx_live  = 4'hF;
    name_live = 8'hFF;
    num_phase = SZ_WAIT;
    num_acc   = '0;
  endfunction

  function automatic void clear_line();
    stack_val = '0;
    heap_val  = '0;
    doe_seen  = 1'b0;
    level_val = '0;
    level_set = 1'b0;
    clear_token();
  endfunction

  // Decimal digits, then an optional K/M/G scale; the rest of the value is ignored
  function automatic void size_char(input logic [7:0] c);
    logic        is_digit;
    logic [63:0] dval;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dval     = {56'd0, c - CH_ZERO};
    case (num_phase)
      SZ_WAIT: begin
        num_acc   = is_digit ? dval : '0;
        num_phase = is_digit ? SZ_DIGITS : SZ_DONE;
      end
      SZ_DIGITS: begin
        if (is_digit) begin
          num_acc = num_acc * 64'd10 + dval;
        end else begin
          if (c == "K" || c == "k") num_acc = num_acc << 10;
          else if (c == "M" || c == "m") num_acc = num_acc << 20;
          else if (c == "G" || c == "g") num_acc = num_acc << 30;
          num_phase = SZ_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int p;
    int li;
    p = int'(tok_len);
    for (int k = 0; k < 4; k++)
      if (p < pfx_text[k].len() && c != 8'(pfx_text[k][p])) pfx_live[k] = 1'b0;
    if (pfx_live[PFX_LEVEL] && p >= pfx_text[PFX_LEVEL].len()) begin
      li = p - pfx_text[PFX_LEVEL].len();
      for (int k = 0; k < 8; k++)
        if (li < lvl_text[k].len() && c != 8'(lvl_text[k][li])) name_live[k] = 1'b0;
    end
    if ((pfx_live[PFX_STACK] && p >= pfx_text[PFX_STACK].len()) ||
        (pfx_live[PFX_HEAP] && p >= pfx_text[PFX_HEAP].len()))
      size_char(c);
    if (tok_len != POS_MAX) tok_len = tok_len + 5'd1;
    in_tok = 1'b1;
  endfunction

  // Close the open token and apply it; priority doe, level, stack, heap
  function automatic void finish_token();
    int         len;
    int         name_len;
    logic [1:0] code;
    logic       picked;
    if (!in_tok) return;
    len = int'(tok_len);
    if (pfx_live[PFX_DOE] && len == pfx_text[PFX_DOE].len()) begin
      doe_seen = 1'b1;
    end else if (pfx_live[PFX_LEVEL] && len > pfx_text[PFX_LEVEL].len()) begin
      name_len = len - pfx_text[PFX_LEVEL].len();
      code     = LVL_INFO;
      picked   = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if (!picked && name_live[k] && name_len >= lvl_text[k].len()) begin
          code   = 2'(k >> 1);
          picked = 1'b1;
        end
      end
      level_val = code;
      level_set = 1'b1;
    end else if (pfx_live[PFX_STACK] && len > pfx_text[PFX_STACK].len()) begin
      stack_val = num_acc;
    end else if (pfx_live[PFX_HEAP] && len > pfx_text[PFX_HEAP].len()) begin
      heap_val = num_acc;
    end
    clear_token();
  endfunction

  function automatic void parse_item(input logic op, input logic [7:0] c);
    boot_opts_t opts;
    if (op == OP_CHAR) begin
      if (is_sep(c)) finish_token();
      else take_char(c);
    end else begin
      finish_token();
      opts.stack = stack_val;
      opts.heap  = heap_val;
      opts.doe   = doe_seen | dflt_doe;
      opts.level = level_set ? level_val : dflt_level;
      expected_opts.push_back(opts);
      clear_line();
    end
  endfunction

  function automatic void report(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch: %s on line %0d, expected %h, got %h", what, lines_checked, want, got);
  endfunction

  function automatic void check_opts();
    boot_opts_t want;
    if (expected_opts.size() == 0) begin
      report("result with nothing expected", 64'd0, stack_bytes_o);
      return;
    end
    want = expected_opts.pop_front();
    if (stack_bytes_o !== want.stack) report("stack bytes", want.stack, stack_bytes_o);
    if (heap_bytes_o !== want.heap) report("heap bytes", want.heap, heap_bytes_o);
    if (run_doe_o !== want.doe) report("run_doe", 64'(want.doe), 64'(run_doe_o));
    if (lvl_code_o !== want.level) report("level code", 64'(want.level), 64'(lvl_code_o));
    lines_checked++;
  endfunction

  int send_gap;

  // Driver: one line byte or end mark per transfer, with random gaps
  always @(posedge clk_i) begin
    line_item_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
      clear_line();
    end else begin
      if (push && !full) begin
        parse_item(op_i, ch_i);
        items_sent++;
      end
      if (push && full) begin
        stall_cycles++;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_items.size() == 0) begin
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 4);
        push <= 1'b0;
      end else begin
        nxt = pending_items.pop_front();
        push <= 1'b1;
        op_i <= nxt.op;
        ch_i <= nxt.ch;
      end
    end
  end

  // Monitor: takes results, with random gaps and one long hold-off
  int  take_gap;
  int  hold_left;
  bit  hold_taken;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_opts();
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Track default register writes
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dflt_doe   <= RST_RUN_DOE;
      dflt_level <= RST_LOG_LEVEL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_RUN_DOE) dflt_doe <= cfg_data_i[0];
      else dflt_level <= cfg_data_i;
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk_i);
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Stimulus helpers
  task automatic add_char(input logic [7:0] c);
    line_item_t it;
    it.op = OP_CHAR;
    it.ch = c;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_end();
    line_item_t it;
    it.op = OP_END;
    it.ch = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(8'(s[i]));
  endtask

  function automatic logic [7:0] token_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_sep(c));
    return c;
  endfunction

  task automatic add_tail(input int max_len);
    repeat ($urandom_range(1, max_len)) add_char(token_byte());
  endtask

  task automatic add_seps();
    repeat ($urandom_range(1, 3)) add_char(sep_list[$urandom_range(0, 3)]);
  endtask

  task automatic add_doe_token();
    case ($urandom_range(0, 4))
      0:       begin add_text("--doe"); add_tail(3); end
      1:       add_text("--do");
      2:       add_text("--dOe");
      default: add_text("--doe");
    endcase
  endtask

  // Level names: none, exact, too short, one letter in the wrong case, random letters
  task automatic add_level_token();
    string nm;
    int    idx;
    nm = lvl_text[$urandom_range(0, 7)];
    add_text(pfx_text[PFX_LEVEL]);
    case ($urandom_range(0, 9))
      0: return;
      1: nm = nm.substr(0, $urandom_range(0, nm.len() - 2));
      2: begin
        idx = $urandom_range(0, nm.len() - 1);
        nm.putc(idx, nm.getc(idx) ^ 8'h20);
      end
      3: begin
        nm = "";
        repeat ($urandom_range(1, 6))
          add_char(8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      end
      default: ;
    endcase
    add_text(nm);
    if ($urandom_range(0, 3) == 0) add_tail(22);
  endtask

  // Sizes: empty, bad first byte, mostly short numbers, some long enough to wrap, optional scale and tail
  task automatic add_size_token();
    int pick;
    add_text($urandom_range(0, 1) ? pfx_text[PFX_STACK] : pfx_text[PFX_HEAP]);
    pick = $urandom_range(0, 9);
    if (pick == 0) return;
    if (pick == 1) add_char(token_byte());
    repeat (($urandom_range(0, 4) == 0) ? $urandom_range(15, 26) : $urandom_range(1, 7))
      add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    pick = $urandom_range(0, 9);
    if (pick < 6) add_char(8'(size_suffix[pick]));
    else if (pick < 8) add_char(token_byte());
    if ($urandom_range(0, 4) == 0) add_tail(6);
  endtask

  task automatic add_broken_token();
    string p;
    p = pfx_text[$urandom_range(0, 3)];
    add_text(p.substr(0, $urandom_range(0, p.len() - 2)));
    if ($urandom_range(0, 1) == 0) add_tail(8);
  endtask

  task automatic add_random_line();
    int ntok;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 30)) add_char(8'($urandom_range(0, 255)));
      add_end();
      return;
    end
    if ($urandom_range(0, 3) == 0) add_seps();
    ntok = $urandom_range(0, 5);
    for (int i = 0; i < ntok; i++) begin
      case ($urandom_range(0, 9))
        0:          add_doe_token();
        1, 2, 8:    add_level_token();
        3, 4, 5, 9: add_size_token();
        6:          add_broken_token();
        default:    add_tail(40);
      endcase
      if (i < ntok - 1 || $urandom_range(0, 2) == 0) add_seps();
    end
    add_end();
  endtask

  task automatic fill_random(input int count);
    int start;
    @(negedge clk_i);
    start = items_queued;
    while (items_queued - start < count) add_random_line();
  endtask

  // Block idle: nothing left to send and every result taken
  task automatic wait_idle();
    while (pending_items.size() != 0 || push || expected_opts.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_default(input logic idx, input logic [1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sequence of phases
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_default(CFG_RUN_DOE, 2'd0);
    write_default(CFG_LOG_LEVEL, 2'd0);
    @(negedge clk_i);
    // empty line, extreme bytes, every separator, doe, scaled heap, empty stack value
    add_end();
    add_char(8'h00);
    add_char(8'hFF);
    add_char(CH_TAB);
    add_text("--doe");
    add_char(CH_CR);
    add_text("--heap=3g");
    add_char(CH_LF);
    add_end();
    add_text("--stack=");
    add_char(CH_SPACE);
    add_end();
    fill_random(330);
    wait_idle();

    // Receiver holds off while a run of end marks backs up the block
    write_default(CFG_RUN_DOE, 2'd1);
    write_default(CFG_LOG_LEVEL, 2'd3);
    @(negedge clk_i);
    hold_req = 1'b1;
    repeat (12) begin
      add_char(token_byte());
      add_end();
    end
    fill_random(400);
    wait_idle();

    write_default(CFG_RUN_DOE, 2'd0);
    write_default(CFG_LOG_LEVEL, 2'd2);
    fill_random(400);
    wait_idle();

    // Last stretch with no idling on either side
    write_default(CFG_RUN_DOE, 2'd1);
    write_default(CFG_LOG_LEVEL, 2'd1);
    @(negedge clk_i);
    quiet = 1'b1;
    fill_random(450);
    wait_idle();

    $display("sent %0d bytes and end marks, checked %0d option sets, %0d input stall cycles",
             items_sent, lines_checked, stall_cycles);
    $display("four default settings, a long result hold-off and a final stretch without gaps");
    if (mismatches == 0 && expected_opts.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/bopt_pkg.sv
rtl/bopt_front.sv
rtl/bopt_back.sv
rtl/boot_option_token_parser.sv
test/tb.sv
